@@ design/alignment_cigar_run_encoder_assert.svh @@
// Assertion macros for the CIGAR run encoder checker.
// Used by acre_checker; expects clk and rst_n in the including scope.
`ifndef ALIGNMENT_CIGAR_RUN_ENCODER_ASSERT_SVH
`define ALIGNMENT_CIGAR_RUN_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define ACRE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ACRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/acre_pkg.sv @@
// Shared types and constants for the alignment CIGAR run encoder.
// No dependencies; used by every design file but the assertion header.
package acre_pkg;

    localparam int MAX_COLUMNS_DEF = 65536;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;
    localparam int OFFSET_W    = 31;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_IMMEDIATELY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FINISH_AT_END     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_OFFSET  = 2'd2;

    // Result field widths
    localparam int OP_W     = 2;
    localparam int LEN_W    = 17;
    localparam int QSTART_W = 18;
    localparam int QEND_W   = 17;
    localparam int RSTART_W = 33;
    localparam int REND_W   = 32;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Column class; NONE marks columns before the alignment has begun
    typedef enum logic [2:0] {
        KIND_MATCH = 3'd0,
        KIND_INS   = 3'd1,
        KIND_DEL   = 3'd2,
        KIND_CLIP  = 3'd3,
        KIND_NONE  = 3'd4
    } kind_t;

    typedef enum logic [OP_W-1:0] {
        OP_MATCH = 2'd0,
        OP_INS   = 2'd1,
        OP_DEL   = 2'd2,
        OP_CLIP  = 2'd3
    } op_t;

    typedef struct packed {
        logic                start_immediately;
        logic                finish_at_end;
        logic [OFFSET_W-1:0] reference_offset;
    } acre_cfg_t;

    // One queued work record: an optional finished run and an optional close
    typedef struct packed {
        logic                       run_valid;
        op_t                        run_op;
        logic [LEN_W-1:0]           run_len;
        logic                       is_last;
        logic                       fin_present;
        op_t                        fin_op;
        logic [LEN_W-1:0]           fin_len;
        logic signed [QSTART_W-1:0] q_start;
        logic [QEND_W-1:0]          q_end;
        logic signed [RSTART_W-1:0] r_first;
        logic [REND_W-1:0]          r_end;
    } acre_entry_t;

    function automatic op_t kind_to_op(kind_t k);
        op_t o;
        unique case (k)
            KIND_MATCH: o = OP_MATCH;
            KIND_INS:   o = OP_INS;
            KIND_DEL:   o = OP_DEL;
            KIND_CLIP:  o = OP_CLIP;
            default:    o = OP_MATCH;
        endcase
        return o;
    endfunction

endpackage

@@ design/acre_if.sv @@
// Stream interfaces for the CIGAR run encoder: columns in, results out.
// Depends on acre_pkg for field widths.
interface acre_column_if;
    logic valid;
    logic ready;
    logic query_is_gap;
    logic ref_is_gap;
    logic last_column;

    modport source (output valid, output query_is_gap, output ref_is_gap,
                    output last_column, input ready);
    modport sink   (input valid, input query_is_gap, input ref_is_gap,
                    input last_column, output ready);
endinterface

interface acre_result_if;
    logic                                valid;
    logic                                ready;
    logic [acre_pkg::OP_W-1:0]           op;
    logic [acre_pkg::LEN_W-1:0]          run_length;
    logic                                run_present;
    logic                                summary_valid;
    logic signed [acre_pkg::QSTART_W-1:0] query_start;
    logic [acre_pkg::QEND_W-1:0]         query_end;
    logic signed [acre_pkg::RSTART_W-1:0] ref_start;
    logic [acre_pkg::REND_W-1:0]         ref_end;

    modport source (output valid, output op, output run_length, output run_present,
                    output summary_valid, output query_start, output query_end,
                    output ref_start, output ref_end, input ready);
    modport sink   (input valid, input op, input run_length, input run_present,
                    input summary_valid, input query_start, input query_end,
                    input ref_start, input ref_end, output ready);
endinterface

@@ design/acre_front.sv @@
// Front part: accepts columns, classifies them, tracks runs and positions.
// Depends on acre_pkg and acre_column_if; feeds work records to acre_queue.
module acre_front #(
    parameter int MAX_COLUMNS = acre_pkg::MAX_COLUMNS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    acre_column_if.sink           columns,
    input  acre_pkg::acre_cfg_t   cfg,
    input  logic                  queue_full,
    output logic                  push_valid,
    output acre_pkg::acre_entry_t push_data
);
    import acre_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_COLUMNS);

    function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] x);
        return (x < CNT_MAX) ? CW'(x + 1'b1) : x;
    endfunction

    logic               started_reg, started_next;
    logic               qseen_reg, qseen_next;
    logic               rseen_reg, rseen_next;
    kind_t              kind_reg, kind_next;
    logic [CW-1:0]      rcount_reg, rcount_next;
    logic [CW-1:0]      qbases_reg, qbases_next;
    logic [CW-1:0]      rbases_reg, rbases_next;
    logic signed [CW:0] qfirst_reg, qfirst_next;
    logic signed [CW:0] rfirst_reg, rfirst_next;
    logic               first_col_reg, first_col_next;

    logic               accept;
    logic               qg, rg, last;
    logic               started0, qseen0, rseen0, start_now, started1;
    logic signed [CW:0] qfirst0, rfirst0, qfirst1, rfirst1;
    logic [CW-1:0]      qbases0, rbases0, qbases1, rbases1, rcount0, rcount1;
    kind_t              kind, kind0, fin_kind;
    logic               same, emit;
    logic [CW-1:0]      qend, rend;

    assign qg = columns.query_is_gap;
    assign rg = columns.ref_is_gap;
    assign last = columns.last_column;

    assign columns.ready = !queue_full;
    assign accept = columns.valid && !queue_full;

    // Per-alignment state, reloaded on the first column
    always_comb
    begin
        if (first_col_reg)
        begin
            started0 = cfg.start_immediately;
            qseen0   = cfg.start_immediately;
            rseen0   = cfg.start_immediately;
            qfirst0  = cfg.start_immediately ? '0 : '1;
            rfirst0  = cfg.start_immediately ? '0 : '1;
            qbases0  = '0;
            rbases0  = '0;
            rcount0  = '0;
        end
        else
        begin
            started0 = started_reg;
            qseen0   = qseen_reg;
            rseen0   = rseen_reg;
            qfirst0  = qfirst_reg;
            rfirst0  = rfirst_reg;
            qbases0  = qbases_reg;
            rbases0  = rbases_reg;
            rcount0  = rcount_reg;
        end
    end

    // Alignment start detection and column class
    always_comb
    begin
        qseen_next = qseen0 || !qg;
        rseen_next = rseen0 || !rg;
        start_now  = qseen_next && rseen_next && !started0;
        started1   = started0 || start_now;
        qfirst1    = start_now ? $signed({1'b0, qbases0}) : qfirst0;
        rfirst1    = start_now ? $signed({1'b0, rbases0}) : rfirst0;

        if (qg)
            kind = started1 ? KIND_DEL : KIND_NONE;
        else if (rg)
            kind = started1 ? KIND_INS : KIND_CLIP;
        else
            kind = KIND_MATCH;

        kind0   = first_col_reg ? kind : kind_reg;
        same    = (kind == kind0);
        rcount1 = same ? sat_inc(rcount0) : CW'(1);
        emit    = !same && (kind0 != KIND_NONE);
        qbases1 = qg ? qbases0 : sat_inc(qbases0);
        rbases1 = rg ? rbases0 : sat_inc(rbases0);
    end

    // If not finish_at_end: trailing insertion becomes clip, deletion vanishes
    always_comb
    begin
        fin_kind = kind;
        qend     = qbases1;
        rend     = rbases1;
        if (kind == KIND_INS && !cfg.finish_at_end)
        begin
            fin_kind = KIND_CLIP;
            qend     = (rcount1 <= qbases1) ? CW'(qbases1 - rcount1) : '0;
        end
        else if (kind == KIND_DEL && !cfg.finish_at_end)
        begin
            fin_kind = KIND_NONE;
            rend     = (rcount1 <= rbases1) ? CW'(rbases1 - rcount1) : '0;
        end
    end

    // Work record
    always_comb
    begin
        push_valid            = accept && (emit || last);
        push_data.run_valid   = emit;
        push_data.run_op      = kind_to_op(kind0);
        push_data.run_len     = LEN_W'(rcount0);
        push_data.is_last     = last;
        push_data.fin_present = (fin_kind != KIND_NONE);
        push_data.fin_op      = (fin_kind != KIND_NONE) ? kind_to_op(fin_kind) : OP_MATCH;
        push_data.fin_len     = (fin_kind != KIND_NONE) ? LEN_W'(rcount1) : '0;
        push_data.q_start     = QSTART_W'(qfirst1);
        push_data.q_end       = QEND_W'(qend);
        push_data.r_first     = RSTART_W'(rfirst1);
        push_data.r_end       = REND_W'(rend);
    end

    // Next state: hold, advance, or clear after the closing column
    always_comb
    begin
        started_next   = started_reg;
        kind_next      = kind_reg;
        rcount_next    = rcount_reg;
        qbases_next    = qbases_reg;
        rbases_next    = rbases_reg;
        qfirst_next    = qfirst_reg;
        rfirst_next    = rfirst_reg;
        first_col_next = first_col_reg;
        if (accept)
        begin
            if (last)
            begin
                started_next   = 1'b0;
                kind_next      = KIND_MATCH;
                rcount_next    = '0;
                qbases_next    = '0;
                rbases_next    = '0;
                qfirst_next    = '1;
                rfirst_next    = '1;
                first_col_next = 1'b1;
            end
            else
            begin
                started_next   = started1;
                kind_next      = kind;
                rcount_next    = rcount1;
                qbases_next    = qbases1;
                rbases_next    = rbases1;
                qfirst_next    = qfirst1;
                rfirst_next    = rfirst1;
                first_col_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            qseen_reg     <= 1'b0;
            rseen_reg     <= 1'b0;
            kind_reg      <= KIND_MATCH;
            rcount_reg    <= '0;
            qbases_reg    <= '0;
            rbases_reg    <= '0;
            qfirst_reg    <= '1;
            rfirst_reg    <= '1;
            first_col_reg <= 1'b1;
        end
        else
        begin
            started_reg   <= started_next;
            kind_reg      <= kind_next;
            rcount_reg    <= rcount_next;
            qbases_reg    <= qbases_next;
            rbases_reg    <= rbases_next;
            qfirst_reg    <= qfirst_next;
            rfirst_reg    <= rfirst_next;
            first_col_reg <= first_col_next;
            if (accept)
            begin
                qseen_reg <= last ? 1'b0 : qseen_next;
                rseen_reg <= last ? 1'b0 : rseen_next;
            end
        end
    end

endmodule

@@ design/acre_queue.sv @@
// Short FIFO of work records between the front and back parts.
// Depends on acre_pkg for the record type and depth.
module acre_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  acre_pkg::acre_entry_t push_data,
    input  logic                  pop,
    output acre_pkg::acre_entry_t pop_data,
    output logic                  full,
    output logic                  empty
);
    import acre_pkg::*;

    acre_entry_t       slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ design/acre_back.sv @@
// Back part: turns work records into result transfers through an output register.
// Depends on acre_pkg and acre_result_if; drains acre_queue.
module acre_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  acre_pkg::acre_entry_t             pop_data,
    input  logic                              queue_empty,
    input  logic [acre_pkg::OFFSET_W-1:0]     reference_offset,
    output logic                              pop,
    acre_result_if.source                     results
);
    import acre_pkg::*;

    logic                       valid_reg, valid_next;
    logic                       phase_reg, phase_next;
    op_t                        op_reg;
    logic [LEN_W-1:0]           len_reg;
    logic                       present_reg;
    logic                       summary_reg;
    logic signed [QSTART_W-1:0] qstart_reg;
    logic [QEND_W-1:0]          qend_reg;
    logic signed [RSTART_W-1:0] rstart_reg;
    logic [REND_W-1:0]          rend_reg;

    logic load, show_run;

    // A record carrying a run and a close takes two transfers
    assign load     = !queue_empty && (!valid_reg || results.ready);
    assign show_run = pop_data.run_valid && !phase_reg;
    assign pop      = load && !(show_run && pop_data.is_last);

    always_comb
    begin
        phase_next = load ? (show_run && pop_data.is_last) : phase_reg;
        if (load)
            valid_next = 1'b1;
        else if (results.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (show_run)
            begin
                op_reg      <= pop_data.run_op;
                len_reg     <= pop_data.run_len;
                present_reg <= 1'b1;
                summary_reg <= 1'b0;
                qstart_reg  <= '0;
                qend_reg    <= '0;
                rstart_reg  <= '0;
                rend_reg    <= '0;
            end
            else
            begin
                op_reg      <= pop_data.fin_op;
                len_reg     <= pop_data.fin_len;
                present_reg <= pop_data.fin_present;
                summary_reg <= 1'b1;
                qstart_reg  <= pop_data.q_start;
                qend_reg    <= pop_data.q_end;
                rstart_reg  <= pop_data.r_first
                               + $signed(RSTART_W'(reference_offset));
                rend_reg    <= pop_data.r_end + REND_W'(reference_offset);
            end
        end
    end

    assign results.valid         = valid_reg;
    assign results.op            = op_reg;
    assign results.run_length    = len_reg;
    assign results.run_present   = present_reg;
    assign results.summary_valid = summary_reg;
    assign results.query_start   = qstart_reg;
    assign results.query_end     = qend_reg;
    assign results.ref_start     = rstart_reg;
    assign results.ref_end       = rend_reg;

endmodule

@@ design/alignment_cigar_run_encoder.sv @@
// Top level of the alignment CIGAR run encoder: config registers, front, queue, back.
// Depends on acre_pkg, acre_if, acre_front, acre_queue and acre_back.
//
// Usage:
//   columns: one alignment column per transfer (query gap, reference gap, last flag).
//   results: run ops (op, run_length) and, on the last column, a closing result
//            with query start/end and offset reference start/end.
//   cfg_write/cfg_index/cfg_data: register writes, to be made by the user only while
//   idle; the block itself does not enforce this.
// A column's record passes through the queue, then the output register; the second
//   result of a closing column is loaded once the first is taken.
// Throughput: one column per cycle while the queue is not full. A column yields zero,
//   one or two results; a last column that also closes a run needs two transfers from
//   the single output register, and the four-entry queue absorbs that.
// Reset: registers clear, the next column starts a new alignment, no results pending.
// Receiver stall: the output register holds its result; the queue fills and
//   columns.ready drops only once all four entries are occupied.
module alignment_cigar_run_encoder #(
    parameter int MAX_COLUMNS = acre_pkg::MAX_COLUMNS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [acre_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [acre_pkg::CFG_DATA_W-1:0]     cfg_data,
    acre_column_if.sink                         columns,
    acre_result_if.source                       results
);
    import acre_pkg::*;

    acre_cfg_t   cfg_reg;
    acre_entry_t push_data, pop_data;
    logic        push_valid, pop, queue_full, queue_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_IMMEDIATELY: cfg_reg.start_immediately <= cfg_data[0];
                CFG_FINISH_AT_END:     cfg_reg.finish_at_end     <= cfg_data[0];
                CFG_REFERENCE_OFFSET:  cfg_reg.reference_offset  <= cfg_data;
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    acre_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .columns    (columns),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    acre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    acre_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_data         (pop_data),
        .queue_empty      (queue_empty),
        .reference_offset (cfg_reg.reference_offset),
        .pop              (pop),
        .results          (results)
    );

endmodule

@@ design/acre_checker.sv @@
// Port-level checker for the CIGAR run encoder's result channel, bound to the top.
// Depends on acre_pkg and alignment_cigar_run_encoder_assert.svh.
`include "alignment_cigar_run_encoder_assert.svh"

module acre_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 valid,
    input logic                                 ready,
    input logic [acre_pkg::OP_W-1:0]            op,
    input logic [acre_pkg::LEN_W-1:0]           run_length,
    input logic                                 run_present,
    input logic                                 summary_valid,
    input logic signed [acre_pkg::QSTART_W-1:0] query_start,
    input logic [acre_pkg::QEND_W-1:0]          query_end,
    input logic signed [acre_pkg::RSTART_W-1:0] ref_start,
    input logic [acre_pkg::REND_W-1:0]          ref_end
);
    import acre_pkg::*;

    // A result without a run carries a zero op and length
    `ACRE_ASSERT_NOW(a_no_run_zero, valid && !run_present, op == OP_MATCH && run_length == '0, "result without run has nonzero op or length")

    // Only the closing result may lack a run
    `ACRE_ASSERT_NOW(a_mid_has_run, valid && !summary_valid, run_present, "non-closing result without a run")

    // Positions are zero outside the closing result
    `ACRE_ASSERT_NOW(a_mid_no_pos, valid && !summary_valid, query_start == '0 && query_end == '0 && ref_start == '0 && ref_end == '0, "non-closing result carries positions")

    // Stalled result holds
    `ACRE_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(op) && $stable(run_length) && $stable(summary_valid) && $stable(ref_end), "stalled result changed")

endmodule

bind alignment_cigar_run_encoder acre_checker u_acre_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (results.valid),
    .ready         (results.ready),
    .op            (results.op),
    .run_length    (results.run_length),
    .run_present   (results.run_present),
    .summary_valid (results.summary_valid),
    .query_start   (results.query_start),
    .query_end     (results.query_end),
    .ref_start     (results.ref_start),
    .ref_end       (results.ref_end)
);

@@ verif/tb_alignment_cigar_run_encoder.sv @@
// Testbench for alignment_cigar_run_encoder: drives alignment columns, predicts CIGAR runs
// and closing positions in a local model, and checks every result transfer in order.
// Depends on acre_pkg, acre_if and the design top level.
module tb_alignment_cigar_run_encoder;
    import acre_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int PHASE_COLUMNS  = 340;
    localparam int HEAVY_PCT      = 58;
    localparam int LIGHT_PCT      = 33;
    localparam logic [16:0] COL_LIMIT = 17'(MAX_COLUMNS_DEF);
    localparam logic [30:0] OFFSET_MAX = '1;

    // Column shapes as seen by the sender
    typedef enum logic [1:0] {
        COL_MATCH,
        COL_INS,
        COL_DEL,
        COL_BOTH
    } column_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mix_t;

    typedef struct {
        op_t                op;
        logic [16:0]        run_length;
        logic               run_present;
        logic               summary_valid;
        logic signed [17:0] query_start;
        logic [16:0]        query_end;
        logic signed [32:0] ref_start;
        logic [31:0]        ref_end;
    } cigar_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    acre_column_if col_bus ();
    acre_result_if res_bus ();

    alignment_cigar_run_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .columns   (col_bus),
        .results   (res_bus)
    );

    // Local copy of the registers
    logic        cfg_start_now;
    logic        cfg_keep_tail;
    logic [30:0] cfg_offset;

    // Encoder state mirror
    logic               started;
    logic               query_seen;
    logic               ref_seen;
    kind_t              run_kind;
    logic [16:0]        run_count;
    logic [16:0]        query_bases;
    logic [16:0]        ref_bases;
    logic signed [17:0] query_first;
    logic signed [17:0] ref_first;
    logic               at_first_column;

    cigar_result_t pending_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_requests;
    int cycle_count;
    int columns_sent;
    int alignments_sent;
    int results_checked;
    int inflow_stalls;
    int mismatch_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending_results.size());
        $display("alignment_cigar_run_encoder: mismatch");
        $finish;
    end

    function automatic logic [16:0] sat_step(input logic [16:0] x);
        return (x < COL_LIMIT) ? x + 17'd1 : x;
    endfunction

    function void clear_encoder();
        started         = 1'b0;
        query_seen      = 1'b0;
        ref_seen        = 1'b0;
        run_kind        = KIND_MATCH;
        run_count       = '0;
        query_bases     = '0;
        ref_bases       = '0;
        query_first     = -18'sd1;
        ref_first       = -18'sd1;
        at_first_column = 1'b1;
    endfunction

    // Append one expectation at the tail of the queue
    function void expect_result(input cigar_result_t r);
        pending_results = {pending_results, r};
    endfunction

    // Next state of the encoder for one accepted column, queueing the results it causes
    function void predict_column(input logic qg, input logic rg, input logic last);
        kind_t         col_kind;
        kind_t         fin_kind;
        logic [16:0]   q_end;
        logic [16:0]   r_end;
        cigar_result_t r;
        if (at_first_column)
        begin
            started     = cfg_start_now;
            query_seen  = cfg_start_now;
            ref_seen    = cfg_start_now;
            query_first = cfg_start_now ? 18'sd0 : -18'sd1;
            ref_first   = cfg_start_now ? 18'sd0 : -18'sd1;
            query_bases = '0;
            ref_bases   = '0;
            run_count   = '0;
        end
        if (!qg) query_seen = 1'b1;
        if (!rg) ref_seen = 1'b1;
        // Alignment begins once both rows have shown a base
        if (query_seen && ref_seen && !started)
        begin
            query_first = $signed({1'b0, query_bases});
            ref_first   = $signed({1'b0, ref_bases});
            started     = 1'b1;
        end
        if (qg)
            col_kind = started ? KIND_DEL : KIND_NONE;
        else if (rg)
            col_kind = started ? KIND_INS : KIND_CLIP;
        else
            col_kind = KIND_MATCH;
        if (at_first_column)
        begin
            run_kind        = col_kind;
            at_first_column = 1'b0;
        end
        // Run-length coding; a kind change closes the previous run
        if (col_kind == run_kind)
            run_count = sat_step(run_count);
        else
        begin
            if (run_kind != KIND_NONE)
            begin
                r = '{op: op_t'(run_kind[1:0]), run_length: run_count, run_present: 1'b1,
                      summary_valid: 1'b0, query_start: '0, query_end: '0,
                      ref_start: '0, ref_end: '0};
                expect_result(r);
            end
            run_kind  = col_kind;
            run_count = 17'd1;
        end
        if (!qg) query_bases = sat_step(query_bases);
        if (!rg) ref_bases = sat_step(ref_bases);
        // Closing result, ends trimmed unless the tail is kept
        if (last)
        begin
            q_end    = query_bases;
            r_end    = ref_bases;
            fin_kind = run_kind;
            if (fin_kind == KIND_INS && !cfg_keep_tail)
            begin
                fin_kind = KIND_CLIP;
                q_end    = (run_count <= q_end) ? q_end - run_count : '0;
            end
            else if (fin_kind == KIND_DEL && !cfg_keep_tail)
            begin
                fin_kind = KIND_NONE;
                r_end    = (run_count <= r_end) ? r_end - run_count : '0;
            end
            r.summary_valid = 1'b1;
            r.query_start   = query_first;
            r.query_end     = q_end;
            r.ref_start     = {{15{ref_first[17]}}, ref_first} + {2'b00, cfg_offset};
            r.ref_end       = {15'b0, r_end} + {1'b0, cfg_offset};
            if (fin_kind == KIND_NONE)
            begin
                r.op          = OP_MATCH;
                r.run_length  = '0;
                r.run_present = 1'b0;
            end
            else
            begin
                r.op          = op_t'(fin_kind[1:0]);
                r.run_length  = run_count;
                r.run_present = 1'b1;
            end
            expect_result(r);
            clear_encoder();
        end
    endfunction

    function void check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Result checker: every result transfer against the oldest expectation
    initial
    begin
        cigar_result_t got;
        cigar_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                got.op            = op_t'(res_bus.op);
                got.run_length    = res_bus.run_length;
                got.run_present   = res_bus.run_present;
                got.summary_valid = res_bus.summary_valid;
                got.query_start   = res_bus.query_start;
                got.query_end     = res_bus.query_end;
                got.ref_start     = res_bus.ref_start;
                got.ref_end       = res_bus.ref_end;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with none expected, expected nothing, got op %0d len %0d",
                             $time, got.op, got.run_length);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("op", 64'(want.op), 64'(got.op));
                    check_field("run_length", 64'(want.run_length), 64'(got.run_length));
                    check_field("run_present", 64'(want.run_present), 64'(got.run_present));
                    check_field("summary_valid", 64'(want.summary_valid),
                                64'(got.summary_valid));
                    check_field("query_start", 64'(want.query_start), 64'(got.query_start));
                    check_field("query_end", 64'(want.query_end), 64'(got.query_end));
                    check_field("ref_start", 64'(want.ref_start), 64'(got.ref_start));
                    check_field("ref_end", 64'(want.ref_end), 64'(got.ref_end));
                    results_checked++;
                end
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    initial
    begin
        int holdoff_served;
        int holdoff_left;
        holdoff_served = 0;
        holdoff_left   = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_served != holdoff_requests)
            begin
                holdoff_served = holdoff_requests;
                holdoff_left   = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                res_bus.ready <= 1'b0;
                holdoff_left--;
            end
            else
                res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one column and wait for its transfer
    task automatic push_column(input column_t c, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            col_bus.valid <= 1'b0;
            @(posedge clk);
        end
        col_bus.valid        <= 1'b1;
        col_bus.query_is_gap <= (c == COL_DEL || c == COL_BOTH);
        col_bus.ref_is_gap   <= (c == COL_INS || c == COL_BOTH);
        col_bus.last_column  <= last;
        @(posedge clk);
        while (!col_bus.ready)
        begin
            inflow_stalls++;
            @(posedge clk);
        end
        predict_column(c == COL_DEL || c == COL_BOTH, c == COL_INS || c == COL_BOTH, last);
        columns_sent++;
        if (last) alignments_sent++;
    endtask

    // One alignment from a string of M, I, D, B (both gaps); last column on the final char
    task automatic send_pattern(input string pat);
        column_t c;
        for (int i = 0; i < pat.len(); i++)
        begin
            case (pat[i])
                "I":     c = COL_INS;
                "D":     c = COL_DEL;
                "B":     c = COL_BOTH;
                default: c = COL_MATCH;
            endcase
            push_column(c, i == pat.len() - 1);
        end
    endtask

    // Wait until every expected result has arrived and the pipeline is quiet
    task automatic settle_outputs();
        col_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers while idle
    task automatic program_registers(input logic start_now, input logic keep_tail,
                                     input logic [30:0] offset);
        settle_outputs();
        for (int i = 0; i < 3; i++)
        begin
            cfg_write <= 1'b1;
            case (i)
                0:
                begin
                    cfg_index <= CFG_START_IMMEDIATELY;
                    cfg_data  <= {30'b0, start_now};
                end
                1:
                begin
                    cfg_index <= CFG_FINISH_AT_END;
                    cfg_data  <= {30'b0, keep_tail};
                end
                default:
                begin
                    cfg_index <= CFG_REFERENCE_OFFSET;
                    cfg_data  <= offset;
                end
            endcase
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cfg_start_now = start_now;
        cfg_keep_tail = keep_tail;
        cfg_offset    = offset;
    endtask

    task automatic set_idling(input idle_mix_t mix);
        send_idle_pct  = (mix == IDLE_SENDER)   ? HEAVY_PCT :
                         (mix == IDLE_BOTH)     ? LIGHT_PCT : 0;
        recv_stall_pct = (mix == IDLE_RECEIVER) ? HEAVY_PCT :
                         (mix == IDLE_BOTH)     ? LIGHT_PCT : 0;
    endtask

    // Short alignments: every op, never-started, trailing trims, both gaps, one column
    task automatic test_directed_columns();
        set_idling(IDLE_NONE);
        program_registers(1'b0, 1'b0, '0);
        send_pattern("BD");
        send_pattern("IIMDMII");
        send_pattern("MDD");
        program_registers(1'b1, 1'b1, OFFSET_MAX);
        send_pattern("DIMBD");
        send_pattern("M");
        send_pattern("IMI");
    endtask

    // Receiver holds off while the sender keeps offering run-closing columns
    task automatic test_backpressure();
        set_idling(IDLE_NONE);
        program_registers(1'b0, 1'b1, 31'd1000);
        holdoff_requests++;
        for (int i = 0; i < 80; i++)
            push_column((i % 2 == 0) ? COL_MATCH : COL_INS, i == 79);
    endtask

    task automatic send_random_alignment();
        int      len;
        int      pick;
        bit      tidy;
        column_t c;
        tidy = ($urandom_range(99) < 80);
        len  = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        c    = column_t'($urandom_range(3));
        for (int i = 0; i < len; i++)
        begin
            // Tidy alignments repeat the previous shape to build real runs
            if (!(tidy && i > 0 && $urandom_range(99) < 60))
            begin
                pick = $urandom_range(9);
                c = (pick < 4) ? COL_MATCH : (pick < 6) ? COL_INS :
                    (pick < 8) ? COL_DEL : COL_BOTH;
            end
            push_column(c, i == len - 1);
        end
    endtask

    // Random alignments under one idling mix, with register changes between groups
    task automatic test_random_mix(input idle_mix_t mix);
        int          phase_start;
        int          pick;
        logic [30:0] offset;
        phase_start = columns_sent;
        set_idling(mix);
        while (columns_sent - phase_start < PHASE_COLUMNS)
        begin
            pick   = $urandom_range(3);
            offset = (pick == 0) ? '0 : (pick == 1) ? OFFSET_MAX : 31'($urandom);
            program_registers(1'($urandom_range(1)), 1'($urandom_range(1)), offset);
            repeat (4) send_random_alignment();
        end
    endtask

    initial
    begin
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        holdoff_requests = 0;
        columns_sent     = 0;
        alignments_sent  = 0;
        results_checked  = 0;
        inflow_stalls    = 0;
        mismatch_count   = 0;
        cfg_start_now    = 1'b0;
        cfg_keep_tail    = 1'b0;
        cfg_offset       = '0;
        clear_encoder();
        rst_n                <= 1'b0;
        cfg_write            <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        col_bus.valid        <= 1'b0;
        col_bus.query_is_gap <= 1'b0;
        col_bus.ref_is_gap   <= 1'b0;
        col_bus.last_column  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_columns();
        test_backpressure();
        test_random_mix(IDLE_NONE);
        test_random_mix(IDLE_SENDER);
        test_random_mix(IDLE_RECEIVER);
        test_random_mix(IDLE_BOTH);

        settle_outputs();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: expected %0d more results, got none", $time,
                     pending_results.size());
        end
        $display("covered %0d columns in %0d alignments, %0d results checked",
                 columns_sent, alignments_sent, results_checked);
        $display("incl. trims, never-started runs, a long receiver hold-off (%0d stall cycles)",
                 inflow_stalls);
        if (mismatch_count == 0)
            $display("alignment_cigar_run_encoder: match");
        else
            $display("alignment_cigar_run_encoder: mismatch");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/acre_pkg.sv
design/acre_if.sv
design/acre_front.sv
design/acre_queue.sv
design/acre_back.sv
design/alignment_cigar_run_encoder.sv
design/acre_checker.sv
verif/tb_alignment_cigar_run_encoder.sv
